// File: rtl/core/button_gesture_decoder_defines.svh
// Assertion macros shared by the button gesture decoder RTL.
// Needs a clk and an active-low rst_n in the scope where the macros are used.
`ifndef BUTTON_GESTURE_DECODER_DEFINES_SVH
`define BUTTON_GESTURE_DECODER_DEFINES_SVH
`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset.
`define BGD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bgd assertion failed");
// Check that a condition implies another one in the next cycle.
`define BGD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bgd sequence assertion failed");
`else
`define BGD_ASSERT(lbl, cond)
`define BGD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/core/bgd_pkg.sv
// Package of the button gesture decoder: action codes, result slots and register indexes.
// Has no dependencies; imported by button_gesture_decoder.
package bgd_pkg;

    localparam int BUTTONS = 4;
    localparam int CFG_W   = 24;
    localparam int TIME_W  = 32;

    typedef enum logic [3:0] {
        ACT_PLAY   = 4'd0,
        ACT_PREV   = 4'd1,
        ACT_NEXT   = 4'd2,
        ACT_VDN    = 4'd3,
        ACT_VUP    = 4'd4,
        ACT_NDEC   = 4'd5,
        ACT_NINC   = 4'd6,
        ACT_SLEEP  = 4'd7,
        ACT_EMERG  = 4'd8,
        ACT_DIAG   = 4'd9,
        ACT_BATT   = 4'd10,
        ACT_MODE   = 4'd11,
        ACT_READY  = 4'd12,
        ACT_ACTIVE = 4'd13
    } action_t;

    // Button indexes.
    localparam logic [1:0] BTN_A = 2'd0;
    localparam logic [1:0] BTN_B = 2'd1;
    localparam logic [1:0] BTN_C = 2'd2;
    localparam logic [1:0] BTN_D = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_DOUBLE_WIN  = 2'd1;
    localparam logic [1:0] REG_EMERG_HOLD  = 2'd2;
    localparam logic [1:0] REG_NIGHT_HOLD  = 2'd3;

    // Result slots, in the order results leave the block.
    localparam int SLOT_NSLEEP = 4;
    localparam int SLOT_DIAG   = 5;
    localparam int SLOT_EMERG  = 6;
    localparam int SLOT_READY  = 7;
    localparam int SLOT_BATT   = 8;
    localparam int SLOT_MODE   = 9;
    localparam int SLOT_CSLEEP = 10;
    localparam int SLOT_CCLICK = 11;
    localparam int SLOT_DCLICK = 12;
    localparam int SLOT_FINA   = 13;
    localparam int SLOT_FINB   = 14;
    localparam int NUM_SLOTS   = 15;

    localparam logic [1:0] CLICK_MAX = 2'd2;

endpackage

// File: rtl/core/button_gesture_decoder.sv
// Top level of the button gesture decoder: poll register, gesture logic and result slots.
// Depends on bgd_pkg and on button_gesture_decoder_defines.svh for assertions.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall   | levels_down, press_edges, now_ms, flags
//  out     | output    | out_valid/out_stall | action, button, last
//  cfg     | input     | cfg_wr_en           | cfg_addr, cfg_data
//
// A poll is held in the input register, then all its results are computed together into a row
// of result slots. The slots drain one result per cycle while the output is not stalled; the
// next poll is evaluated in the cycle the last result leaves.
// Reset clears all gesture state and loads default timings.
// A stalled output holds its result; the input stalls while a registered poll waits on queued results.
`include "button_gesture_decoder_defines.svh"

module button_gesture_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [3:0]                  levels_down,
    input  logic [3:0]                  press_edges,
    input  logic [31:0]                 now_ms,
    input  logic                        night_mode,
    input  logic                        music_mode,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [3:0]                  action,
    output logic [1:0]                  button,
    output logic                        last,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [bgd_pkg::CFG_W-1:0]   cfg_data
);
    import bgd_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] lpt_reg, dcw_reg, eht_reg, nsh_reg;

    // Poll register.
    logic              inv_reg;
    logic [3:0]        lv_reg, pe_reg;
    logic [TIME_W-1:0] now_reg;
    logic              night_reg, music_reg;

    // Gesture state.
    logic [TIME_W-1:0] ps_reg [BUTTONS];
    logic [TIME_W-1:0] ps_next [BUTTONS];
    logic [BUTTONS-1:0] el_reg, lh_reg, cs_reg, el_next, lh_next, cs_next;
    logic [1:0]        cc_reg [2];
    logic [1:0]        cc_next [2];
    logic [TIME_W-1:0] lr_reg [2];
    logic [TIME_W-1:0] lr_next [2];
    logic              combo_reg, srs_reg, nsd_reg, combo_next, srs_next, nsd_next;

    // Result slots.
    logic [NUM_SLOTS-1:0] pend_reg, pend_next, slot_new;
    logic [3:0]           sact_reg [NUM_SLOTS];
    logic [3:0]           sact_new [NUM_SLOTS];
    logic [1:0]           sbtn_reg [NUM_SLOTS];
    logic [1:0]           sbtn_new [NUM_SLOTS];

    logic proc, out_take, in_take;

    assign out_take = out_valid && !out_stall;
    assign proc     = inv_reg && (pend_reg == '0 || (out_take && $onehot(pend_reg)));
    assign in_stall = inv_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    // Gesture evaluation of the registered poll against the current state.
    always_comb
    begin
        logic [TIME_W-1:0] ps1 [BUTTONS];
        logic [BUTTONS-1:0] el1, down, newp, rel;
        logic [TIME_W-1:0] d [BUTTONS];
        logic [TIME_W-1:0] later, dl;
        logic [TIME_W-1:0] lpt, dcw, eht, nsh;
        logic nsleep, diag, emerg, ready, batt, mode, music2, e0, csleep;
        logic [1:0] clicks;
        logic fin;

        lpt  = {8'd0, lpt_reg};
        dcw  = {8'd0, dcw_reg};
        eht  = {8'd0, eht_reg};
        nsh  = {8'd0, nsh_reg};
        down = lv_reg;
        el1  = el_reg | pe_reg;
        slot_new = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            sact_new[s] = ACT_ACTIVE;
            sbtn_new[s] = BTN_A;
        end

        // New presses.
        lh_next = lh_reg;
        cs_next = cs_reg;
        for (int i = 0; i < BUTTONS; i++)
        begin
            newp[i] = down[i] && el1[i] && (ps_reg[i] == '0);
            ps1[i]  = newp[i] ? now_reg : ps_reg[i];
            d[i]    = now_reg - ps1[i];
            if (newp[i])
            begin
                lh_next[i] = 1'b0;
                cs_next[i] = 1'b0;
            end
            slot_new[i] = newp[i] && !night_reg && (now_reg != '0);
            sact_new[i] = ACT_ACTIVE;
            sbtn_new[i] = 2'(i);
        end
        cc_next  = cc_reg;
        lr_next  = lr_reg;
        srs_next = srs_reg;
        nsd_next = nsd_reg;
        combo_next = combo_reg;

        // Night hold of C.
        nsleep = night_reg && down[BTN_C] && (ps1[BTN_C] != '0) && (d[BTN_C] >= nsh)
                 && !nsd_reg;
        if (nsleep)
        begin
            nsd_next = 1'b1;
            lh_next[BTN_C] = 1'b1;
            cs_next[BTN_C] = 1'b1;
        end
        slot_new[SLOT_NSLEEP] = nsleep;
        sact_new[SLOT_NSLEEP] = ACT_SLEEP;
        sbtn_new[SLOT_NSLEEP] = BTN_C;

        // A plus B diagnostic combo.
        later = (ps1[BTN_A] > ps1[BTN_B]) ? ps1[BTN_A] : ps1[BTN_B];
        dl    = now_reg - later;
        diag  = !night_reg && down[BTN_A] && down[BTN_B] && !combo_reg &&
                (ps1[BTN_A] != '0) && (ps1[BTN_B] != '0) && (dl >= lpt);
        if (diag)
        begin
            combo_next = 1'b1;
            lh_next[BTN_A] = 1'b1;
            lh_next[BTN_B] = 1'b1;
            cs_next[BTN_A] = 1'b1;
            cs_next[BTN_B] = 1'b1;
            cc_next[0] = '0;
            cc_next[1] = '0;
            lr_next[0] = '0;
            lr_next[1] = '0;
        end
        slot_new[SLOT_DIAG] = diag;
        sact_new[SLOT_DIAG] = ACT_DIAG;
        sbtn_new[SLOT_DIAG] = BTN_A;

        // Holds of C in day mode.
        e0    = !night_reg && down[BTN_C] && !down[BTN_D] && (ps1[BTN_C] != '0);
        emerg = e0 && (d[BTN_C] >= eht) && !lh_next[BTN_C];
        ready = e0 && (d[BTN_C] >= lpt) && !srs_reg;
        if (emerg)
        begin
            lh_next[BTN_C] = 1'b1;
            cs_next[BTN_C] = 1'b1;
        end
        if (ready)
        begin
            srs_next = 1'b1;
            cs_next[BTN_C] = 1'b1;
        end
        slot_new[SLOT_EMERG] = emerg;
        sact_new[SLOT_EMERG] = ACT_EMERG;
        sbtn_new[SLOT_EMERG] = BTN_C;
        slot_new[SLOT_READY] = ready;
        sact_new[SLOT_READY] = ACT_READY;
        sbtn_new[SLOT_READY] = BTN_C;

        // Long presses of A and B alone.
        batt = !night_reg && down[BTN_A] && !down[BTN_B] && (ps1[BTN_A] != '0) &&
               (d[BTN_A] >= lpt) && !lh_next[BTN_A];
        mode = !night_reg && down[BTN_B] && !down[BTN_A] && (ps1[BTN_B] != '0) &&
               (d[BTN_B] >= lpt) && !lh_next[BTN_B];
        if (batt)
        begin
            lh_next[BTN_A] = 1'b1;
            cs_next[BTN_A] = 1'b1;
            cc_next[0] = '0;
            lr_next[0] = '0;
        end
        if (mode)
        begin
            lh_next[BTN_B] = 1'b1;
            cs_next[BTN_B] = 1'b1;
            cc_next[1] = '0;
            lr_next[1] = '0;
        end
        music2 = music_reg ^ mode;
        slot_new[SLOT_BATT] = batt;
        sact_new[SLOT_BATT] = ACT_BATT;
        sbtn_new[SLOT_BATT] = BTN_A;
        slot_new[SLOT_MODE] = mode;
        sact_new[SLOT_MODE] = ACT_MODE;
        sbtn_new[SLOT_MODE] = BTN_B;

        // Releases; a released button had no hold gesture this poll.
        el_next = el1;
        csleep  = 1'b0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            rel[i] = !down[i] && (ps1[i] != '0);
            ps_next[i] = ps1[i];
            if (rel[i])
            begin
                if (i < 2)
                begin
                    if (!lh_reg[i] && !cs_reg[i] && (d[i] < lpt))
                    begin
                        cc_next[i[0]] = (cc_reg[i[0]] >= CLICK_MAX) ? CLICK_MAX
                                                                   : cc_reg[i[0]] + 2'd1;
                        lr_next[i[0]] = now_reg;
                    end
                    else
                    begin
                        cc_next[i[0]] = '0;
                        lr_next[i[0]] = '0;
                    end
                end
                el_next[i] = 1'b0;
                ps_next[i] = '0;
                lh_next[i] = 1'b0;
                cs_next[i] = 1'b0;
            end
        end
        if (rel[BTN_C])
        begin
            csleep   = !night_reg && !down[BTN_D] && (d[BTN_C] >= lpt) && !lh_reg[BTN_C];
            srs_next = 1'b0;
            nsd_next = 1'b0;
        end
        slot_new[SLOT_CSLEEP] = csleep;
        sact_new[SLOT_CSLEEP] = ACT_SLEEP;
        sbtn_new[SLOT_CSLEEP] = BTN_C;
        slot_new[SLOT_CCLICK] = rel[BTN_C] && !lh_reg[BTN_C] && !cs_reg[BTN_C] &&
                                (d[BTN_C] < lpt);
        sact_new[SLOT_CCLICK] = night_reg ? ACT_NDEC : ACT_VDN;
        sbtn_new[SLOT_CCLICK] = BTN_C;
        slot_new[SLOT_DCLICK] = rel[BTN_D] && !lh_reg[BTN_D] && !cs_reg[BTN_D] &&
                                (d[BTN_D] < lpt);
        sact_new[SLOT_DCLICK] = night_reg ? ACT_NINC : ACT_VUP;
        sbtn_new[SLOT_DCLICK] = BTN_D;

        // Resolve pending clicks of A and B after the quiet window.
        for (int i = 0; i < 2; i++)
        begin
            clicks = cc_next[i];
            fin = (clicks != '0) && (ps_next[i] == '0) && ((now_reg - lr_next[i]) >= dcw);
            if (fin)
            begin
                cc_next[i] = '0;
                lr_next[i] = '0;
            end
            slot_new[SLOT_FINA + i] = fin && !night_reg && music2 &&
                                      ((i == 0) || (clicks >= CLICK_MAX));
            sact_new[SLOT_FINA + i] = (i == 0) ? ((clicks >= CLICK_MAX) ? ACT_PREV : ACT_PLAY)
                                               : ACT_NEXT;
            sbtn_new[SLOT_FINA + i] = 2'(i);
        end

        if (!down[BTN_A] || !down[BTN_B])
        begin
            combo_next = 1'b0;
        end
    end

    // Drain of the result slots, lowest slot first.
    always_comb
    begin
        logic found;
        found  = 1'b0;
        action = ACT_ACTIVE;
        button = BTN_A;
        pend_next = pend_reg;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (pend_reg[s] && !found)
            begin
                found  = 1'b1;
                action = sact_reg[s];
                button = sbtn_reg[s];
                if (out_take)
                begin
                    pend_next[s] = 1'b0;
                end
            end
        end
        if (proc)
        begin
            pend_next = slot_new;
        end
    end

    assign out_valid = |pend_reg;
    assign last      = $onehot(pend_reg);

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpt_reg   <= CFG_W'(1000);
            dcw_reg   <= CFG_W'(400);
            eht_reg   <= CFG_W'(10000);
            nsh_reg   <= CFG_W'(3000);
            inv_reg   <= 1'b0;
            pend_reg  <= '0;
            el_reg    <= '0;
            lh_reg    <= '0;
            cs_reg    <= '0;
            combo_reg <= 1'b0;
            srs_reg   <= 1'b0;
            nsd_reg   <= 1'b0;
            for (int i = 0; i < BUTTONS; i++)
            begin
                ps_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                cc_reg[i] <= '0;
                lr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_LONG_PRESS: lpt_reg <= cfg_data;
                    REG_DOUBLE_WIN: dcw_reg <= cfg_data;
                    REG_EMERG_HOLD: eht_reg <= cfg_data;
                    REG_NIGHT_HOLD: nsh_reg <= cfg_data;
                    default:        lpt_reg <= lpt_reg;
                endcase
            end
            if (in_take)
            begin
                inv_reg <= 1'b1;
            end
            else if (proc)
            begin
                inv_reg <= 1'b0;
            end
            pend_reg <= pend_next;
            if (proc)
            begin
                el_reg    <= el_next;
                lh_reg    <= lh_next;
                cs_reg    <= cs_next;
                combo_reg <= combo_next;
                srs_reg   <= srs_next;
                nsd_reg   <= nsd_next;
                for (int i = 0; i < BUTTONS; i++)
                begin
                    ps_reg[i] <= ps_next[i];
                end
                for (int i = 0; i < 2; i++)
                begin
                    cc_reg[i] <= cc_next[i];
                    lr_reg[i] <= lr_next[i];
                end
            end
        end
    end

    // Payload registers of the poll and of the result slots.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lv_reg    <= levels_down;
            pe_reg    <= press_edges;
            now_reg   <= now_ms;
            night_reg <= night_mode;
            music_reg <= music_mode;
        end
        if (proc)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                sact_reg[s] <= sact_new[s];
                sbtn_reg[s] <= sbtn_new[s];
            end
        end
    end

    // Checks on the slot drain.
    `BGD_ASSERT(a_slot_count, $countones(pend_reg) <= 14)
    `BGD_ASSERT(a_proc_drained, !proc || pend_reg == '0 || $onehot(pend_reg))
    `BGD_ASSERT_NEXT(a_more_follow, out_take && !last, out_valid)
    `BGD_ASSERT_NEXT(a_poll_used, proc && !in_take, !inv_reg)

endmodule
